// ----- rtl/grid_raycast_closest_target_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the grid ray cast core
// Clocked concurrent assertions on clk_i, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef GRID_RAYCAST_CLOSEST_TARGET_CORE_ASSERT_SVH
`define GRID_RAYCAST_CLOSEST_TARGET_CORE_ASSERT_SVH

// Check prop on every clock edge outside reset
`define GRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check prop on every clock edge, reset included
`define GRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg
// Types and constants shared by the grid ray cast core and its divider.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned SIDE_W = 64;  // side distance, units 2^-24
  localparam int unsigned LEN_W  = 33;  // step length, units 2^-16
  localparam int unsigned INC_W  = 41;  // step length times 256

  localparam logic [1:0] OP_MAP    = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_FIRE   = 2'd2;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_CLEAR = 16'h0002,
    ST_DIVX  = 16'h0004,
    ST_DIVY  = 16'h0008,
    ST_INITX = 16'h0010,
    ST_INITY = 16'h0020,
    ST_STEP  = 16'h0040,
    ST_CHK   = 16'h0080,
    ST_DIST  = 16'h0100,
    ST_TLOAD = 16'h0200,
    ST_TM0   = 16'h0400,
    ST_TM1   = 16'h0800,
    ST_TM2   = 16'h1000,
    ST_TM3   = 16'h2000,
    ST_TCMP  = 16'h4000,
    ST_OUT   = 16'h8000
  } state_e;

endpackage

// ----- rtl/grc_div.sv -----
// ----------------------------------------------------------------------------
// grc_div
// Restoring divider for the DDA step length: q = 2^30 / a, 2^32 for a of 0.
// ----------------------------------------------------------------------------
module grc_div
  import grc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [15:0]      a_i,
  output logic             done_o,
  output logic [LEN_W-1:0] q_o
);

  logic [15:0]      a_q;
  logic [15:0]      rem_q;
  logic [LEN_W-1:0] q_q;
  logic [4:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [16:0]      trial;

  // Numerator is 2^30: its only set bit enters on the first iteration
  assign trial = {rem_q, (cnt_q == 5'd30)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= (a_i != 16'd0);
        done_q <= (a_i == 16'd0);
        cnt_q  <= 5'd30;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q   <= a_i;
      rem_q <= 16'd0;
      q_q   <= (a_i == 16'd0) ? {1'b1, {(LEN_W-1){1'b0}}} : '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, a_q}) begin
        rem_q      <= 16'(trial - {1'b0, a_q});
        q_q[cnt_q] <= 1'b1;
      end else begin
        rem_q <= trial[15:0];
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

// ----- rtl/grid_raycast_closest_target_core.sv -----
// ----------------------------------------------------------------------------
// grid_raycast_closest_target_core
// Wall map and target table with a DDA ray walk and closest-target scan.
// ----------------------------------------------------------------------------
// After reset the wall map is swept clear, one cell per cycle (MAP_DIM*MAP_DIM
// cells, 4096 by default); no item is taken meanwhile. Map and target writes
// give no result. A fired ray computes two step lengths in the shared divider
// (a zero direction component skips the divide iterations), then walks the DDA
// steps with one map read per step, then scans the target slots, skipping dead
// slots and testing live ones on the shared multiplier; the next item is taken
// once the result sits in the output register.
`include "grid_raycast_closest_target_core_assert.svh"

module grid_raycast_closest_target_core
  import grc_pkg::*;
#(
  parameter int unsigned MAP_DIM     = 64,
  parameter int unsigned MAX_TARGETS = 16,
  parameter int unsigned MAX_STEPS   = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // pos_x[13:0], pos_y[27:14], flag[28], slot[32:29], dir_x[48:33],
  // dir_y[64:49], range_cap[80:65], zero fill
  input  logic [87:0] s_tdata_i,
  // opcode[1:0]
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // hit_found[0], hit_slot[4:1], zero fill
  output logic [7:0]  m_tdata_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned CELLS = MAP_DIM * MAP_DIM;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CDIM  = (MAP_DIM > 64) ? MAP_DIM : 64;
  localparam int unsigned CW    = $clog2(CDIM) + 2;
  localparam int unsigned TIW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned TCW   = $clog2(MAX_TARGETS + 1);
  localparam int unsigned NW    = $clog2(MAX_STEPS + 1);
  localparam logic signed [CW-1:0] CONE = CW'(1);
  localparam logic signed [CW-1:0] CDIM_S = CW'(MAP_DIM);

  // input fields
  logic [13:0] in_px, in_py;
  logic        in_flag;
  logic [3:0]  in_slot;
  logic signed [15:0] in_dx, in_dy;
  logic [15:0] in_cap;
  assign in_px   = s_tdata_i[13:0];
  assign in_py   = s_tdata_i[27:14];
  assign in_flag = s_tdata_i[28];
  assign in_slot = s_tdata_i[32:29];
  assign in_dx   = s_tdata_i[48:33];
  assign in_dy   = s_tdata_i[64:49];
  assign in_cap  = s_tdata_i[80:65];

  state_e state_q;
  logic   s_xfer;
  assign s_tready_o = (state_q == ST_IDLE);
  assign s_xfer     = s_tvalid_i && s_tready_o;

  logic [15:0] hit_width_q;

  // ray registers
  logic [13:0] px_q, py_q;
  logic signed [15:0] dx_q, dy_q;
  logic [15:0] cap_q;
  logic [LEN_W-1:0] lx_q, ly_q;
  logic [INC_W-1:0] incx_q, incy_q;
  logic [SIDE_W-1:0] sx_q, sy_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic on_x_q, oob_q;
  logic [NW-1:0] n_q;
  logic [15:0] lim_q;

  // scan registers
  logic [TCW-1:0] ti_q;
  logic signed [14:0] vx_q, vy_q;
  logic signed [32:0] f_q, p_q, best_f_q;
  logic found_q;
  logic [TIW-1:0] best_q;

  // target table
  logic [MAX_TARGETS-1:0] alive_q;
  logic [27:0] tpos_q [MAX_TARGETS];

  // output register
  logic       m_tvalid_q;
  logic [7:0] m_tdata_q;

  // divider
  logic div_start, div_done;
  logic [15:0] div_a;
  logic [LEN_W-1:0] div_q;
  logic [15:0] adx_in, ady;

  assign adx_in = in_dx[15] ? 16'(-in_dx) : in_dx;
  assign ady    = dy_q[15] ? 16'(-dy_q) : dy_q;
  assign div_start = (s_xfer && s_tuser_i == OP_FIRE) || (state_q == ST_DIVX && div_done);
  assign div_a     = (state_q == ST_IDLE) ? adx_in : ady;

  grc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // wall map
  logic        map_q [CELLS];
  logic [AW-1:0] clr_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, wr_addr;
  logic        mem_wdata, rdata_q;
  logic        wr_cell_ok;

  assign wr_cell_ok = (9'(in_px[13:8]) < 9'(MAP_DIM)) && (9'(in_py[13:8]) < 9'(MAP_DIM));
  assign wr_addr    = AW'(32'(in_py[13:8]) * 32'(MAP_DIM) + 32'(in_px[13:8]));
  assign mem_we     = (state_q == ST_CLEAR) ||
                      (s_xfer && s_tuser_i == OP_MAP && wr_cell_ok);
  assign mem_waddr  = (state_q == ST_CLEAR) ? clr_q : wr_addr;
  assign mem_wdata  = (state_q == ST_CLEAR) ? 1'b0 : in_flag;

  // DDA step
  logic take_x, oob_n;
  logic signed [CW-1:0] cx_n, cy_n;
  assign take_x = sx_q < sy_q;
  assign cx_n   = !take_x ? cx_q : (dx_q[15] ? cx_q - CONE : cx_q + CONE);
  assign cy_n   = take_x ? cy_q : (dy_q[15] ? cy_q - CONE : cy_q + CONE);
  assign oob_n  = (cx_n < 0) || (cy_n < 0) || (cx_n >= CDIM_S) || (cy_n >= CDIM_S);
  assign mem_raddr = AW'(32'(unsigned'(cy_n)) * 32'(MAP_DIM) + 32'(unsigned'(cx_n)));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == ST_STEP) begin
      rdata_q <= map_q[mem_raddr];
    end
  end

  // start side distance: fraction times step length
  logic [8:0]  fsel;
  logic [41:0] side0;
  always_comb begin
    if (state_q == ST_INITX) begin
      fsel  = dx_q[15] ? {1'b0, px_q[7:0]} : 9'(9'd256 - {1'b0, px_q[7:0]});
      side0 = 42'(fsel * lx_q);
    end else begin
      fsel  = dy_q[15] ? {1'b0, py_q[7:0]} : 9'(9'd256 - {1'b0, py_q[7:0]});
      side0 = 42'(fsel * ly_q);
    end
  end

  // wall distance
  logic [SIDE_W-1:0] diff;
  logic [15:0] wall_dist;
  assign diff = on_x_q ? sx_q - SIDE_W'(incx_q) : sy_q - SIDE_W'(incy_q);
  assign wall_dist = (|diff[SIDE_W-1:32]) ? 16'hFFFF : diff[31:16];

  // shared multiplier for the target tests
  logic signed [14:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [30:0] prod;
  logic [TIW-1:0] tidx;
  logic [27:0] tpos;
  assign tidx  = ti_q[TIW-1:0];
  assign tpos  = tpos_q[tidx];
  assign mul_a = (state_q == ST_TM0 || state_q == ST_TM3) ? vx_q : vy_q;
  assign mul_b = (state_q == ST_TM0 || state_q == ST_TM2) ? dx_q : dy_q;
  assign prod  = mul_a * mul_b;

  logic signed [32:0] pabs, wid_f, lim_f;
  logic take_t;
  assign pabs   = p_q[32] ? -p_q : p_q;
  assign wid_f  = $signed({3'b000, hit_width_q, 14'd0});
  assign lim_f  = $signed({3'b000, lim_q, 14'd0});
  assign take_t = (f_q > 0) && (pabs <= wid_f) && (f_q < lim_f) &&
                  (!found_q || f_q < best_f_q);

  logic [8:0] slot_w;
  assign slot_w = 9'(in_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hit_width_q <= 16'd77;
      alive_q     <= '0;
      m_tvalid_q  <= 1'b0;
      n_q         <= '0;
      ti_q        <= '0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hit_width_q <= cfg_wdata_i;
      end
      if (m_tvalid_q && m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_xfer) begin
            if (s_tuser_i == OP_TARGET && slot_w < 9'(MAX_TARGETS)) begin
              alive_q[slot_w[TIW-1:0]] <= in_flag;
            end
            if (s_tuser_i == OP_FIRE) begin
              state_q <= ST_DIVX;
            end
          end
        end
        ST_DIVX: if (div_done) state_q <= ST_DIVY;
        ST_DIVY: if (div_done) state_q <= ST_INITX;
        ST_INITX: state_q <= ST_INITY;
        ST_INITY: begin
          state_q <= ST_STEP;
          n_q     <= '0;
        end
        ST_STEP: begin
          n_q     <= n_q + NW'(1);
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (oob_q || rdata_q || n_q == NW'(MAX_STEPS)) begin
            state_q <= ST_DIST;
          end else begin
            state_q <= ST_STEP;
          end
        end
        ST_DIST: begin
          state_q <= ST_TLOAD;
          ti_q    <= '0;
          found_q <= 1'b0;
        end
        ST_TLOAD: begin
          if (ti_q == TCW'(MAX_TARGETS)) begin
            state_q <= ST_OUT;
          end else if (alive_q[tidx]) begin
            state_q <= ST_TM0;
          end else begin
            ti_q <= ti_q + TCW'(1);
          end
        end
        ST_TM0: state_q <= ST_TM1;
        ST_TM1: state_q <= ST_TM2;
        ST_TM2: state_q <= ST_TM3;
        ST_TM3: state_q <= ST_TCMP;
        ST_TCMP: begin
          if (take_t) begin
            found_q <= 1'b1;
          end
          ti_q    <= ti_q + TCW'(1);
          state_q <= ST_TLOAD;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid_q || m_tready_i) begin
            m_tvalid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_xfer && s_tuser_i == OP_TARGET && slot_w < 9'(MAX_TARGETS)) begin
      tpos_q[slot_w[TIW-1:0]] <= {in_py, in_px};
    end
    case (state_q)
      ST_IDLE: begin
        px_q  <= in_px;
        py_q  <= in_py;
        dx_q  <= in_dx;
        dy_q  <= in_dy;
        cap_q <= in_cap;
      end
      ST_DIVX: if (div_done) lx_q <= div_q;
      ST_DIVY: if (div_done) ly_q <= div_q;
      ST_INITX: begin
        sx_q   <= SIDE_W'(side0);
        incx_q <= {lx_q, 8'd0};
        cx_q   <= $signed({{(CW-6){1'b0}}, px_q[13:8]});
        on_x_q <= 1'b0;
      end
      ST_INITY: begin
        sy_q   <= SIDE_W'(side0);
        incy_q <= {ly_q, 8'd0};
        cy_q   <= $signed({{(CW-6){1'b0}}, py_q[13:8]});
      end
      ST_STEP: begin
        if (take_x) begin
          sx_q <= sx_q + SIDE_W'(incx_q);
        end else begin
          sy_q <= sy_q + SIDE_W'(incy_q);
        end
        cx_q   <= cx_n;
        cy_q   <= cy_n;
        on_x_q <= take_x;
        oob_q  <= oob_n;
      end
      ST_DIST: lim_q <= (wall_dist < cap_q) ? wall_dist : cap_q;
      ST_TLOAD: begin
        vx_q <= $signed({1'b0, tpos[13:0]}) - $signed({1'b0, px_q});
        vy_q <= $signed({1'b0, tpos[27:14]}) - $signed({1'b0, py_q});
      end
      ST_TM0: f_q <= 33'(prod);
      ST_TM1: f_q <= f_q + 33'(prod);
      ST_TM2: p_q <= 33'(prod);
      ST_TM3: p_q <= p_q - 33'(prod);
      ST_TCMP: begin
        if (take_t) begin
          best_f_q <= f_q;
          best_q   <= tidx;
        end
      end
      ST_OUT: begin
        if (!m_tvalid_q || m_tready_i) begin
          m_tdata_q <= {3'b000, found_q ? 4'(best_q) : 4'd0, found_q};
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  `GRC_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `GRC_ASSERT(a_steps_bounded, n_q <= NW'(MAX_STEPS), "DDA step count past limit")
  `GRC_ASSERT(a_no_hit_slot_zero, (m_tvalid_o && !m_tdata_o[0]) |-> (m_tdata_o[4:1] == 4'd0), "slot set without a hit")
  `GRC_ASSERT(a_clear_blocks, (state_q == ST_CLEAR) |-> !s_tready_o, "input taken during map clear")
  `GRC_ASSERT(a_out_from_scan, $rose(m_tvalid_o) |-> $past(state_q == ST_OUT), "result raised outside output step")

endmodule
